FILE: rtl/kcms_pkg.sv
// Package for the k-mer context match search block.
// Holds the beat types, function and register codes, and the group-difference counter.
// Used by kcms_ctrl, kcms_datapath and kmer_context_match_search.
package kcms_pkg;

  localparam int unsigned KmerW     = 64;
  localparam int unsigned GroupCnt  = KmerW / 2;
  localparam int unsigned DistW     = 7;
  localparam int unsigned MaxDistW  = 6;
  localparam int unsigned BaseW     = 2;
  localparam int unsigned MatchIdxW = 6;
  localparam int unsigned GrpCntW   = 6;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 8;

  // Function codes carried by an input beat. Code 3 is unused.
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MAX_DISTANCE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HIST_BASE    = 8'd1;

  typedef struct packed {
    logic [1:0]       func;
    logic [KmerW-1:0] left_kmer;
    logic [KmerW-1:0] right_kmer;
    logic [BaseW-1:0] query_base;
  } kcms_in_t;

  typedef struct packed {
    logic [DistW-1:0]     distance;
    logic                 match_found;
    logic [MatchIdxW-1:0] match_index;
  } kcms_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // a query beat is accepted this cycle
    logic wr_en;     // append the input pair at the write address
    logic rd_en;     // read the entry at the read address
    logic flush;     // drop everything in the compare pipeline
    logic load_out;  // move the finished result into the output register
  } kcms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic base_miss; // query base differs from the stored set's base
    logic done;      // the scan has settled its result this cycle
  } kcms_status_t;

  // Number of 2-bit groups that differ between a and b, summed as a tree.
  function automatic logic [GrpCntW-1:0] group_diffs(input logic [KmerW-1:0] a,
                                                     input logic [KmerW-1:0] b);
    logic [KmerW-1:0]   d;
    logic [GrpCntW-1:0] acc [GroupCnt];
    d = a ^ b;
    for (int g = 0; g < GroupCnt; g++) begin
      acc[g] = {{(GrpCntW-1){1'b0}}, |d[2*g +: 2]};
    end
    for (int lvl = 0; lvl < 5; lvl++) begin
      for (int j = 0; j < GroupCnt / 2; j++) begin
        if (j < ((GroupCnt / 2) >> lvl)) begin
          acc[j] = acc[2*j] + acc[2*j+1];
        end
      end
    end
    return acc[0];
  endfunction

endpackage

FILE: rtl/kcms_ctrl.sv
// Controller of the k-mer context match search block.
// Sequences clear, append and query beats, the table scan and the output handshake.
// Depends on kcms_pkg.
module kcms_ctrl import kcms_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned CNT_W       = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       func_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output kcms_cmd_t        cmd_o,
  input  kcms_status_t     status_i,
  output logic [IDX_W-1:0] wr_addr_o,
  output logic [IDX_W-1:0] rd_addr_o,
  output logic             rd_last_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;
  logic             scan_last;
  logic             out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign scan_last  = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wr_addr_o   = IDX_W'(count_q);
  assign rd_addr_o   = addr_q;
  assign rd_last_o   = scan_last;
  assign out_valid_o = out_valid_q;

  // Next-state and command logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    addr_d      = addr_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (func_i == FUNC_CLEAR) begin
            count_d = '0;
          end else if (func_i == FUNC_APPEND) begin
            if (count_q < CNT_W'(TABLE_DEPTH)) begin
              cmd_o.wr_en = 1'b1;
              count_d     = count_q + CNT_W'(1);
            end
          end else if (func_i == FUNC_QUERY) begin
            cmd_o.start = 1'b1;
            addr_d      = '0;
            if (status_i.base_miss || (count_q == '0)) begin
              state_d = ST_FINISH;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (status_i.done) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          if (scan_last) begin
            state_d = ST_WAIT;
          end else begin
            addr_d = addr_q + IDX_W'(1);
          end
        end
      end
      ST_WAIT: begin
        if (status_i.done) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a load, cleared once the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/kcms_datapath.sv
// Datapath of the k-mer context match search block.
// Holds the flank tables, configuration registers, compare pipeline and result registers.
// Depends on kcms_pkg.
module kcms_datapath import kcms_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned IDX_W       = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcms_in_t            in_data_i,
  output kcms_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  kcms_cmd_t           cmd_i,
  output kcms_status_t        status_o,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  input  logic                rd_last_i
);

  logic [KmerW-1:0]    left_mem  [TABLE_DEPTH];
  logic [KmerW-1:0]    right_mem [TABLE_DEPTH];

  logic [MaxDistW-1:0] max_dist_q;
  logic [BaseW-1:0]    hist_base_q;
  logic [KmerW-1:0]    qry_left_q, qry_right_q;

  // Stage one: read data from the tables.
  logic [KmerW-1:0]    rd_left_q, rd_right_q;
  logic                s1_valid_q, s1_last_q;
  logic [IDX_W-1:0]    s1_idx_q;

  // Stage two: per-flank mismatch counts.
  logic [GrpCntW-1:0]  cnt_left_q, cnt_right_q;
  logic                s2_valid_q, s2_last_q;
  logic [IDX_W-1:0]    s2_idx_q;

  logic [DistW-1:0]    best_q, best_d;
  kcms_out_t           result_q, result_d;
  kcms_out_t           out_q;

  logic [DistW-1:0]    cap;
  logic [DistW-1:0]    sum;
  logic [DistW-1:0]    best_new;
  logic                hit_cap, hit_zero;

  assign cap        = {max_dist_q, 1'b0};
  assign sum        = DistW'(cnt_left_q) + DistW'(cnt_right_q);
  assign hit_cap    = (sum >= cap);
  assign hit_zero   = (sum == '0);
  assign best_new   = (sum > best_q) ? sum : best_q;
  assign out_data_o = out_q;

  assign status_o.base_miss = (in_data_i.query_base != hist_base_q);
  assign status_o.done      = s2_valid_q && (hit_cap || hit_zero || s2_last_q);

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= MaxDistW'(1);
      hist_base_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MAX_DISTANCE) begin
        max_dist_q <= cfg_data_i[MaxDistW-1:0];
      end else if (cfg_index_i == REG_HIST_BASE) begin
        hist_base_q <= cfg_data_i[BaseW-1:0];
      end
    end
  end

  // Flank tables with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      left_mem[wr_addr_i]  <= in_data_i.left_kmer;
      right_mem[wr_addr_i] <= in_data_i.right_kmer;
    end
    if (cmd_i.rd_en) begin
      rd_left_q  <= left_mem[rd_addr_i];
      rd_right_q <= right_mem[rd_addr_i];
    end
  end

  // Query flanks and the mismatch counts.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qry_left_q  <= in_data_i.left_kmer;
      qry_right_q <= in_data_i.right_kmer;
    end
    cnt_left_q  <= group_diffs(rd_left_q, qry_left_q);
    cnt_right_q <= group_diffs(rd_right_q, qry_right_q);
    s1_idx_q    <= rd_addr_i;
    s2_idx_q    <= s1_idx_q;
    s1_last_q   <= rd_last_i;
    s2_last_q   <= s1_last_q;
  end

  // Pipeline valid bits; a flush drops every entry in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd_en && !cmd_i.flush;
      s2_valid_q <= s1_valid_q && !cmd_i.flush;
    end
  end

  // Running maximum and the settled result.
  always_comb begin
    best_d   = best_q;
    result_d = result_q;
    if (cmd_i.start) begin
      best_d   = '0;
      result_d = '0;
      if (status_o.base_miss) begin
        result_d.distance = cap + DistW'(1);
      end
    end else if (s2_valid_q) begin
      if (hit_cap) begin
        result_d.distance = cap;
      end else if (hit_zero) begin
        result_d.match_found = 1'b1;
        result_d.match_index = MatchIdxW'(s2_idx_q);
      end else if (s2_last_q) begin
        result_d.distance = best_new;
      end else begin
        best_d = best_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    result_q <= result_d;
    if (cmd_i.load_out) begin
      out_q <= result_q;
    end
  end

endmodule

FILE: rtl/kmer_context_match_search.sv
// Top level of the k-mer context match search block.
// Joins the controller and the datapath; depends on kcms_pkg, kcms_ctrl and kcms_datapath.
//
// The block keeps a table of up to TABLE_DEPTH pairs of 32-base flanking k-mers and answers
// queries with a capped Hamming distance counted over 2-bit base groups. Clear and append
// beats complete without leaving the idle state. A query whose base differs from hist_base,
// or that meets an empty table, skips the scan and goes straight to its result. Otherwise
// the table is read one entry per cycle through the single read port of the flank memories,
// and each entry passes a two-stage compare pipeline; a cap hit or an exact match ends the
// scan early. The output register holds a finished result while the next beat is accepted.
// Configuration writes are always ready and take effect on the next cycle.
module kmer_context_match_search import kcms_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kcms_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kcms_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  kcms_cmd_t       cmd;
  kcms_status_t    status;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;
  logic            rd_last;

  assign cfg_ready_o = 1'b1;

  // Sequencing of beats and the table scan.
  kcms_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IdxW),
    .CNT_W      (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (in_data_i.func),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .rd_last_o  (rd_last)
  );

  // Tables, compare pipeline and result registers.
  kcms_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IdxW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .wr_addr_i  (wr_addr),
    .rd_addr_i  (rd_addr),
    .rd_last_i  (rd_last)
  );

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the k-mer context match search block.
// Depends on kcms_pkg and kmer_context_match_search; it predicts every query result itself.
`timescale 1ns / 1ps

module tb_top;
  import kcms_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_HI = 8'hFF;
  localparam logic [KmerW-1:0]   ALL_ONES = {KmerW{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall_o;
  kcms_in_t            in_data = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  kcms_out_t           out_data_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  kmer_context_match_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Shadow of the block: flank table, entry count and the two registers.
  logic [KmerW-1:0]    tbl_left  [TABLE_DEPTH];
  logic [KmerW-1:0]    tbl_right [TABLE_DEPTH];
  int unsigned         tbl_count = 0;
  logic [MaxDistW-1:0] cfg_max_dist = 6'd1;
  logic [BaseW-1:0]    cfg_hist_base = 2'd0;

  kcms_in_t    pending_beats [$];
  kcms_out_t   query_results_q [$];
  kcms_out_t   want_res;
  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;

  // Table content as the stimulus generator sees it, ahead of the driver.
  logic [KmerW-1:0] gen_left [$];
  logic [KmerW-1:0] gen_right [$];
  int unsigned      made = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Counts the 2-bit base groups that differ between two k-mers.
  function automatic int unsigned group_mismatches(logic [KmerW-1:0] a, logic [KmerW-1:0] b);
    logic [KmerW-1:0] d;
    int unsigned n;
    d = a ^ b;
    n = 0;
    for (int g = 0; g < int'(GroupCnt); g++) begin
      if (d[2*g +: 2] != 2'b00) n++;
    end
    return n;
  endfunction

  // Applies one accepted beat to the shadow and queues the result of a query.
  function automatic void predict_search(kcms_in_t b);
    int unsigned cap;
    int unsigned tot;
    int unsigned best;
    bit          settled;
    kcms_out_t   res;
    case (b.func)
      FUNC_CLEAR: tbl_count = 0;
      FUNC_APPEND: begin
        if (tbl_count < TABLE_DEPTH) begin
          tbl_left[tbl_count]  = b.left_kmer;
          tbl_right[tbl_count] = b.right_kmer;
          tbl_count++;
        end
      end
      FUNC_QUERY: begin
        cap = 2 * cfg_max_dist;
        best = 0;
        settled = 1'b0;
        res = '0;
        if (b.query_base != cfg_hist_base) begin
          res.distance = DistW'(cap + 1);
        end else begin
          // The cap test comes first, so a zero cap never reports an exact match.
          for (int i = 0; i < int'(tbl_count) && !settled; i++) begin
            tot = group_mismatches(tbl_left[i], b.left_kmer)
                + group_mismatches(tbl_right[i], b.right_kmer);
            if (tot >= cap) begin
              res.distance = DistW'(cap);
              settled = 1'b1;
            end else if (tot == 0) begin
              res.match_found = 1'b1;
              res.match_index = MatchIdxW'(i);
              settled = 1'b1;
            end else if (tot > best) begin
              best = tot;
            end
          end
          if (!settled) res.distance = DistW'(best);
        end
        query_results_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Idle length: mostly none, sometimes a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KmerW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Changes a number of randomly chosen base groups of a k-mer.
  function automatic logic [KmerW-1:0] mutate(logic [KmerW-1:0] k, int unsigned flips);
    logic [KmerW-1:0] m;
    int unsigned g;
    m = k;
    for (int unsigned f = 0; f < flips; f++) begin
      g = $urandom_range(0, GroupCnt - 1);
      m = m ^ (KmerW'($urandom_range(1, 3)) << (2 * g));
    end
    return m;
  endfunction

  // Queues one input beat and tracks the table it will build.
  function automatic void add_beat(logic [1:0] func, logic [KmerW-1:0] lk,
                                   logic [KmerW-1:0] rk, logic [BaseW-1:0] qb);
    kcms_in_t b;
    b.func = func;
    b.left_kmer = lk;
    b.right_kmer = rk;
    b.query_base = qb;
    pending_beats.push_back(b);
    if (func == FUNC_CLEAR) begin
      gen_left.delete();
      gen_right.delete();
    end else if (func == FUNC_APPEND && gen_left.size() < TABLE_DEPTH) begin
      gen_left.push_back(lk);
      gen_right.push_back(rk);
    end
    if (func != FUNC_UNUSED) made++;
  endfunction

  // A query mostly near a stored entry, with the configured base most of the time.
  function automatic void add_query();
    int unsigned r;
    int unsigned j;
    int unsigned spread;
    logic [KmerW-1:0] lk;
    logic [KmerW-1:0] rk;
    logic [BaseW-1:0] qb;
    r = $urandom_range(0, 99);
    spread = (cfg_max_dist < 4) ? 3 : cfg_max_dist;
    lk = rand64();
    rk = rand64();
    if (gen_left.size() != 0 && r < 85) begin
      j = $urandom_range(0, gen_left.size() - 1);
      lk = gen_left[j];
      rk = gen_right[j];
      if (r < 65) begin
        lk = mutate(lk, $urandom_range(0, spread));
        rk = mutate(rk, $urandom_range(0, spread));
      end
    end
    qb = ($urandom_range(0, 99) < 85) ? cfg_hist_base : BaseW'($urandom_range(0, 3));
    add_beat(FUNC_QUERY, lk, rk, qb);
  endfunction

  // Random part: table builds followed by queries, with some noise beats.
  function automatic void add_random(int unsigned count);
    int unsigned r;
    int unsigned n;
    logic [KmerW-1:0] seed_l;
    logic [KmerW-1:0] seed_r;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        add_beat(FUNC_UNUSED, rand64(), rand64(), BaseW'($urandom_range(0, 3)));
      end else if (r < 12) begin
        add_query();
      end else begin
        if ($urandom_range(0, 3) != 0) add_beat(FUNC_CLEAR, rand64(), rand64(), 2'($urandom));
        r = $urandom_range(0, 99);
        n = (r < 70) ? $urandom_range(1, 6) : (r < 92) ? $urandom_range(7, 20)
                                                      : $urandom_range(60, 70);
        seed_l = rand64();
        seed_r = rand64();
        for (int unsigned k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) != 0) begin
            add_beat(FUNC_APPEND, mutate(seed_l, $urandom_range(1, 4)),
                     mutate(seed_r, $urandom_range(1, 4)), 2'($urandom));
          end else begin
            add_beat(FUNC_APPEND, rand64(), rand64(), 2'($urandom));
          end
        end
        n = $urandom_range(1, 6);
        for (int unsigned k = 0; k < n; k++) add_query();
      end
    end
  endfunction

  // Writes one configuration register and mirrors it in the shadow.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_DISTANCE) cfg_max_dist = val[MaxDistW-1:0];
    else if (idx == REG_HIST_BASE) cfg_hist_base = val[BaseW-1:0];
  endtask

  // Waits for every beat to go out and every result to come back, then lets the block settle.
  // The check runs at the falling edge so that the driver's updates have landed.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || query_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input driver: presents queued beats with random gaps and predicts each accepted one.
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall_o) predict_search(in_data);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_beats.size() != 0) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stalls, and each accepted result beat checked field by field.
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (query_results_q.size() == 0) begin
          $display("%0t: unexpected result: distance %0d match_found %0b match_index %0d",
                   $realtime, out_data_o.distance, out_data_o.match_found,
                   out_data_o.match_index);
          mismatches++;
        end else begin
          want_res = query_results_q.pop_front();
          if (out_data_o.distance !== want_res.distance) begin
            $display("%0t: distance expected %0d actual %0d", $realtime,
                     want_res.distance, out_data_o.distance);
            mismatches++;
          end
          if (out_data_o.match_found !== want_res.match_found) begin
            $display("%0t: match_found expected %0b actual %0b", $realtime,
                     want_res.match_found, out_data_o.match_found);
            mismatches++;
          end
          if (out_data_o.match_index !== want_res.match_index) begin
            $display("%0t: match_index expected %0d actual %0d", $realtime,
                     want_res.match_index, out_data_o.match_index);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Sequence of phases, each with its own register setting.
  initial begin
    logic [KmerW-1:0] fl [$];
    logic [KmerW-1:0] fr [$];
    logic [KmerW-1:0] a;
    logic [KmerW-1:0] b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: cap 2, base 0.
    add_beat(FUNC_QUERY, '0, '0, 2'd0);                // empty table
    add_beat(FUNC_QUERY, ALL_ONES, ALL_ONES, 2'd3);    // base mismatch
    add_beat(FUNC_UNUSED, ALL_ONES, ALL_ONES, 2'd3);   // unused code, no result
    add_beat(FUNC_APPEND, '0, '0, 2'd0);
    add_beat(FUNC_APPEND, ALL_ONES, ALL_ONES, 2'd3);
    add_beat(FUNC_QUERY, '0, '0, 2'd0);                // exact match on entry 0
    add_beat(FUNC_QUERY, ALL_ONES, ALL_ONES, 2'd0);    // cap hit on the left flank
    add_beat(FUNC_QUERY, 64'h1, '0, 2'd0);             // one group off, then cap
    add_beat(FUNC_QUERY, '0, 64'h3 << 62, 2'd0);       // one group off on the right flank, then cap
    add_beat(FUNC_CLEAR, ALL_ONES, ALL_ONES, 2'd3);
    add_beat(FUNC_APPEND, ALL_ONES, ALL_ONES, 2'd0);
    add_beat(FUNC_QUERY, ALL_ONES ^ (64'h3 << 62), ALL_ONES, 2'd0);  // largest distance kept
    add_beat(FUNC_QUERY, ALL_ONES, ALL_ONES, 2'd1);
    a = rand64();
    b = rand64();
    add_beat(FUNC_APPEND, a, b, 2'd2);
    add_beat(FUNC_QUERY, a, b, 2'd0);
    add_beat(FUNC_CLEAR, '0, '0, 2'd0);
    add_beat(FUNC_QUERY, '0, '0, 2'd0);
    wait_idle();

    // Zero cap: no exact match is ever reported.
    write_reg(REG_MAX_DISTANCE, 8'd0);
    write_reg(REG_HIST_BASE, 8'hFD);
    write_reg(REG_UNMAPPED_LO, 8'hFF);
    add_beat(FUNC_APPEND, a, b, 2'd1);
    add_beat(FUNC_QUERY, a, b, 2'd1);
    add_beat(FUNC_QUERY, a, b, 2'd0);
    add_random(60);
    wait_idle();

    // Largest cap: fill the table past full and match the last entry.
    write_reg(REG_MAX_DISTANCE, 8'hFF);
    write_reg(REG_HIST_BASE, 8'd3);
    add_beat(FUNC_CLEAR, '0, '0, 2'd0);
    for (int k = 0; k < int'(TABLE_DEPTH) + 2; k++) begin
      fl.push_back(rand64());
      fr.push_back(rand64());
      add_beat(FUNC_APPEND, fl[k], fr[k], 2'($urandom));
    end
    add_beat(FUNC_QUERY, fl[TABLE_DEPTH-1], fr[TABLE_DEPTH-1], 2'd3);
    add_beat(FUNC_QUERY, fl[TABLE_DEPTH+1], fr[TABLE_DEPTH+1], 2'd3);
    add_beat(FUNC_QUERY, fl[0], fr[0], 2'd3);
    add_random(60);
    wait_idle();

    // Back-to-back beats with no idling on either side.
    no_idle = 1'b1;
    write_reg(REG_MAX_DISTANCE, 8'd32);
    write_reg(REG_HIST_BASE, 8'hFE);
    add_random(80);
    wait_idle();
    no_idle = 1'b0;

    write_reg(REG_MAX_DISTANCE, 8'd2);
    write_reg(REG_HIST_BASE, 8'd0);
    add_random(80);
    wait_idle();

    // Random settings, mostly small caps so that every outcome shows up.
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(0, 99) < 70) write_reg(REG_MAX_DISTANCE, 8'($urandom_range(1, 6)));
      else write_reg(REG_MAX_DISTANCE, 8'($urandom_range(0, 255)));
      write_reg(REG_HIST_BASE, 8'($urandom_range(0, 255)));
      write_reg(REG_UNMAPPED_HI, 8'($urandom_range(0, 255)));
      add_random(70);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a result that never arrives.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
